/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the solver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define KEA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define KEA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

/* rtl/kea_pkg.sv */
// ----------------------------------------------------------------------------
// kea_pkg
// Shared widths, constants, types and elaboration-time table builders.
// ----------------------------------------------------------------------------
package kea_pkg;

  localparam int DefAngleWidth   = 32;
  localparam int DefCordicStages = 30;

  localparam int MeanW    = 31;
  localparam int EccW     = 32;
  localparam int EaW      = 32;
  localparam int StepW    = 6;
  localparam int ThrW     = 21;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 21;

  localparam logic [ThrW-1:0]  ThrReset   = 21'd1;
  localparam logic [StepW-1:0] LimitReset = 6'd30;

  // pi and CORDIC gain with 60 fraction bits
  localparam logic [63:0] PiQ60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] GainQ60 = 64'd700114967507363238;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD  = 1'b0,
    REG_ITER_LIMIT = 1'b1
  } kea_reg_e;

  typedef struct packed {
    logic load;
    logic reduce;
    logic rotate;
    logic sine;
    logic mult;
    logic update;
    logic check;
    logic finish;
  } kea_cmd_t;

  typedef struct packed {
    logic rot_last;
    logic conv;
    logic lim_hit;
  } kea_sts_t;

  // floor(2^k / d), restoring long division (elaboration only)
  function automatic logic [63:0] pow2_div(input int k, input int d);
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    num = 64'd1 << k;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= 64'(d)) begin
        rem    = rem - 64'(d);
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in Q60 by truncated series
  function automatic logic [63:0] atan_q60(input int i);
    logic [63:0] acc;
    logic        neg;
    acc = '0;
    neg = 1'b0;
    if (i == 0) begin
      acc = PiQ60 >> 2;
    end else begin
      for (int n = 1; i * n < 60; n += 2) begin
        if (neg) acc = acc - pow2_div(60 - i * n, n);
        else     acc = acc + pow2_div(60 - i * n, n);
        neg = ~neg;
      end
    end
    return acc;
  endfunction

  // Q60 positive value to frac bits, round half up
  function automatic logic [63:0] q60_to_frac(input logic [63:0] v, input int frac);
    int sh;
    sh = 60 - frac;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

/* rtl/kea_ctrl.sv */
// ----------------------------------------------------------------------------
// kea_ctrl
// Sequencer: per iteration reduce, CORDIC rotations, sine, multiply, update, check.
// ----------------------------------------------------------------------------
module kea_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  kea_pkg::kea_sts_t sts_i,
  output logic             busy_o,
  output kea_pkg::kea_cmd_t cmd_o
);
  import kea_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_REDUCE = 7'b0000010,
    S_ROT    = 7'b0000100,
    S_SIN    = 7'b0001000,
    S_MUL    = 7'b0010000,
    S_UPD    = 7'b0100000,
    S_CHK    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   stop;

  assign stop = sts_i.conv | sts_i.lim_hit;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start_i) state_d = S_REDUCE;
      S_REDUCE: state_d = S_ROT;
      S_ROT:    if (sts_i.rot_last) state_d = S_SIN;
      S_SIN:    state_d = S_MUL;
      S_MUL:    state_d = S_UPD;
      S_UPD:    state_d = S_CHK;
      S_CHK:    state_d = stop ? S_IDLE : S_REDUCE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && start_i;
    cmd_o.reduce = (state_q == S_REDUCE);
    cmd_o.rotate = (state_q == S_ROT);
    cmd_o.sine   = (state_q == S_SIN);
    cmd_o.mult   = (state_q == S_MUL);
    cmd_o.update = (state_q == S_UPD);
    cmd_o.check  = (state_q == S_CHK);
    cmd_o.finish = (state_q == S_CHK) && stop;
  end

  assign busy_o = (state_q != S_IDLE);

`include "assert_macros.svh"

  `KEA_ASSERT(a_sin_after_last_rot, (state_q == S_SIN) |-> $past(sts_i.rot_last), "sine before last rotation")
  `KEA_ASSERT(a_busy_fall_on_finish, $fell(busy_o) |-> $past(cmd_o.finish), "busy dropped without finish")
  `KEA_ASSERT(a_start_taken, (start_i && state_q == S_IDLE) |=> (state_q == S_REDUCE), "request lost")

endmodule

/* rtl/kea_datapath.sv */
// ----------------------------------------------------------------------------
// kea_datapath
// Angle reduction, iterative CORDIC sine, e*sin multiply, update and check.
// ----------------------------------------------------------------------------
module kea_datapath #(
  parameter int ANGLE_WIDTH   = kea_pkg::DefAngleWidth,
  parameter int CORDIC_STAGES = kea_pkg::DefCordicStages
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  kea_pkg::kea_cmd_t                  cmd_i,
  output kea_pkg::kea_sts_t                  sts_o,
  input  logic                               cfg_we_i,
  input  logic [kea_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [kea_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic signed [kea_pkg::MeanW-1:0]   mean_anomaly_i,
  input  logic [kea_pkg::EccW-1:0]           eccentricity_i,
  output logic                               done_o,
  output logic signed [kea_pkg::EaW-1:0]     eccentric_anomaly_o,
  output logic [kea_pkg::StepW-1:0]          iterations_used_o,
  output logic                               converged_o
);
  import kea_pkg::*;

  localparam int AW    = ANGLE_WIDTH;
  localparam int FRAC  = AW - 4;
  localparam int W2    = AW + 2;
  localparam int IterW = $clog2(CORDIC_STAGES);
  localparam int SinW  = 31;
  localparam int ProdW = 64;

  // angle entry shifts (Q28 -> FRAC)
  localparam int ZUP  = (FRAC >= 28) ? FRAC - 28 : 0;
  localparam int ZDN  = (FRAC < 28) ? 28 - FRAC : 0;
  localparam int ZRSH = (ZDN > 0) ? ZDN - 1 : 0;
  // sine exit shifts (FRAC -> Q28)
  localparam int SDN  = (FRAC > 28) ? FRAC - 28 : 0;
  localparam int SRSH = (SDN > 0) ? SDN - 1 : 0;
  localparam int SUP  = (FRAC < 28) ? 28 - FRAC : 0;

  localparam logic signed [32:0] ZRnd = (ZDN > 0) ? (33'sd1 <<< ZRSH) : 33'sd0;
  localparam logic signed [AW:0] SRnd = (SDN > 0) ? ((AW+1)'(1) <<< SRSH) : '0;

  localparam logic signed [W2-1:0] PiC    = W2'(q60_to_frac(PiQ60, FRAC));
  localparam logic signed [W2-1:0] HalfC  = PiC >>> 1;
  localparam logic signed [W2-1:0] TwoPiC = PiC <<< 1;
  localparam logic signed [AW-1:0] GainC  = AW'(q60_to_frac(GainQ60, FRAC));

  typedef logic signed [AW-1:0] atan_tbl_t [CORDIC_STAGES];

  function automatic atan_tbl_t build_atan();
    atan_tbl_t t;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      t[i] = AW'(q60_to_frac(atan_q60(i), FRAC));
    end
    return t;
  endfunction

  localparam atan_tbl_t AtanTbl = build_atan();

  // control registers
  logic [ThrW-1:0]   thr_q;
  logic [StepW-1:0]  lim_q;
  logic [StepW-1:0]  steps_q;
  logic [IterW-1:0]  iter_q;
  logic              valid_q;

  // payload registers
  logic signed [MeanW-1:0] m_q;
  logic [EccW-1:0]         ecc_q;
  logic signed [EaW-1:0]   e_cur_q, e_new_q, e_new_d;
  logic signed [AW-1:0]    x_q, y_q, z_q, x_d, y_d, z_d;
  logic signed [SinW-1:0]  sin_q, sin_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [EaW-1:0]   res_e_q;
  logic [StepW-1:0]        res_it_q;
  logic                    res_conv_q;

  // combinational
  logic signed [32:0]      e_ext, z_dn;
  logic signed [W2-1:0]    z0, z1, z2, z3;
  logic signed [AW-1:0]    dx, dy, atan_v;
  logic signed [AW:0]      y_rnd;
  logic signed [ProdW-1:0] prod_rnd;
  logic signed [33:0]      e_sum;
  logic signed [32:0]      diff;
  logic [32:0]             mag;
  logic [StepW-1:0]        lim_eff;
  logic [StepW:0]          step_nx;
  logic                    conv, lim_hit;

  // angle reduction into -pi/2..pi/2
  always_comb begin
    e_ext = 33'(e_cur_q);
    z_dn  = (e_ext + ZRnd) >>> ZDN;
    if (FRAC >= 28) z0 = W2'(e_cur_q) <<< ZUP;
    else            z0 = W2'(z_dn);
    z1 = (z0 > PiC) ? z0 - TwoPiC : z0;
    z2 = (z1 < -PiC) ? z1 + TwoPiC : z1;
    if (z2 > HalfC)       z3 = PiC - z2;
    else if (z2 < -HalfC) z3 = -PiC - z2;
    else                  z3 = z2;
  end

  // one CORDIC micro-rotation per cycle
  always_comb begin
    dx     = y_q >>> iter_q;
    dy     = x_q >>> iter_q;
    atan_v = AtanTbl[iter_q];
    if (!z_q[AW-1]) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - atan_v;
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + atan_v;
    end
  end

  // sine to Q1.28, product, update
  always_comb begin
    y_rnd = ((AW+1)'(y_q) + SRnd) >>> SDN;
    if (FRAC >= 28) sin_d = SinW'(y_rnd);
    else            sin_d = SinW'(y_q) <<< SUP;
    prod_d   = signed'({1'b0, ecc_q}) * sin_q;
    prod_rnd = (prod_q + 64'sd2147483648) >>> 32;
    e_sum    = 34'(m_q) + signed'(prod_rnd[33:0]);
    e_new_d  = e_sum[EaW-1:0];
  end

  // convergence and limit status
  always_comb begin
    diff    = 33'(e_new_q) - 33'(e_cur_q);
    mag     = diff[32] ? 33'(-diff) : 33'(diff);
    conv    = (mag < 33'(thr_q));
    lim_eff = (lim_q == '0) ? StepW'(1) : lim_q;
    step_nx = {1'b0, steps_q} + (StepW+1)'(1);
    lim_hit = (step_nx >= {1'b0, lim_eff});
  end

  assign sts_o.rot_last = (iter_q == IterW'(CORDIC_STAGES - 1));
  assign sts_o.conv     = conv;
  assign sts_o.lim_hit  = lim_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= ThrReset;
      lim_q   <= LimitReset;
      steps_q <= '0;
      iter_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish;
      if (cfg_we_i) begin
        unique case (kea_reg_e'(cfg_idx_i))
          REG_THRESHOLD:  thr_q <= cfg_data_i[ThrW-1:0];
          REG_ITER_LIMIT: lim_q <= cfg_data_i[StepW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load)   steps_q <= '0;
      if (cmd_i.check)  steps_q <= step_nx[StepW-1:0];
      if (cmd_i.reduce) iter_q  <= '0;
      if (cmd_i.rotate) iter_q  <= IterW'(iter_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q     <= mean_anomaly_i;
      ecc_q   <= eccentricity_i;
      e_cur_q <= EaW'(mean_anomaly_i);
    end
    if (cmd_i.reduce) begin
      z_q <= AW'(z3);
      x_q <= GainC;
      y_q <= '0;
    end
    if (cmd_i.rotate) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
    if (cmd_i.sine)   sin_q   <= sin_d;
    if (cmd_i.mult)   prod_q  <= prod_d;
    if (cmd_i.update) e_new_q <= e_new_d;
    if (cmd_i.check)  e_cur_q <= e_new_q;
    if (cmd_i.finish) begin
      res_e_q    <= e_new_q;
      res_it_q   <= step_nx[StepW-1:0];
      res_conv_q <= conv;
    end
  end

  assign done_o              = valid_q;
  assign eccentric_anomaly_o = res_e_q;
  assign iterations_used_o   = res_it_q;
  assign converged_o         = res_conv_q;

`include "assert_macros.svh"

  `KEA_ASSERT(a_done_one_cycle, valid_q |=> !valid_q, "done held longer than one cycle")
  `KEA_ASSERT_ALWAYS(a_steps_nonzero, valid_q |-> (res_it_q != '0), "result with zero iterations")
  `KEA_ASSERT(a_mult_after_sine, cmd_i.mult |-> $past(cmd_i.sine), "multiply without fresh sine")

endmodule

/* rtl/kepler_eccentric_anomaly_solver_core.sv */
// ----------------------------------------------------------------------------
// kepler_eccentric_anomaly_solver_core
// Kepler equation solver: E = M + e*sin(E) by fixed-point iteration.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive mean_anomaly_i (Q3.28) and eccentricity_i (Q0.32) with
//   start high; the request is taken at a rising edge where busy is low.
//   Result: done_o pulses for exactly one cycle with eccentric_anomaly_o
//   (Q4.28), iterations_used_o and converged_o. The receiver cannot stall;
//   the result registers hold until the next result.
//   Each iteration runs angle reduction, then the CORDIC_STAGES rotations of
//   the shared one-rotation-per-cycle CORDIC unit, then sine rounding, the
//   e*sin multiply, the update add and the change check. done_o rises at the
//   same edge at which busy drops, and a new request is taken only while busy
//   is low, so the core does not accept a request before its last result.
//   Iteration stops when |change| < convergence threshold (converged_o = 1)
//   or at the iteration limit (converged_o = 0); a limit of zero acts as one.
//   Config: cfg_we_i/cfg_idx_i/cfg_data_i write threshold (index 0) or
//   iteration limit (index 1) with no wait; write only while idle.
//   Reset: asynchronous, active low; returns to idle, threshold 1, limit 30.
// ----------------------------------------------------------------------------
module kepler_eccentric_anomaly_solver_core #(
  parameter int ANGLE_WIDTH   = kea_pkg::DefAngleWidth,
  parameter int CORDIC_STAGES = kea_pkg::DefCordicStages
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             start,
  output logic                             busy,
  input  logic signed [kea_pkg::MeanW-1:0] mean_anomaly_i,
  input  logic [kea_pkg::EccW-1:0]         eccentricity_i,
  // result channel
  output logic                             done_o,
  output logic signed [kea_pkg::EaW-1:0]   eccentric_anomaly_o,
  output logic [kea_pkg::StepW-1:0]        iterations_used_o,
  output logic                             converged_o,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [kea_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [kea_pkg::CfgDataW-1:0]     cfg_data_i
);
  import kea_pkg::*;

  // controller drives the command strobes; datapath reports status back
  kea_cmd_t cmd;
  kea_sts_t sts;

  kea_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  // reduction, CORDIC, multiply and update registers; also holds the
  // configuration registers and the output result registers
  kea_datapath #(
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .mean_anomaly_i      (mean_anomaly_i),
    .eccentricity_i      (eccentricity_i),
    .done_o              (done_o),
    .eccentric_anomaly_o (eccentric_anomaly_o),
    .iterations_used_o   (iterations_used_o),
    .converged_o         (converged_o)
  );

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Kepler eccentric anomaly solver core.
// Requests go in through start/busy and results come back on done_o. A
// bit-exact predictor (CORDIC sine, e*sin product, fixed-point update)
// computes each solution at request time. The run steps through several
// threshold and limit settings, first with directed corner requests and
// then with random mean anomaly and eccentricity values.
// ----------------------------------------------------------------------------
module tb;

  import kea_pkg::*;

  localparam int ANGLE_W  = DefAngleWidth;
  localparam int STAGES   = DefCordicStages;
  localparam int FRAC     = ANGLE_W - 4;
  localparam int WDOG_MAX = 20000;  // covers the slowest solve plus a long gap
  localparam int MAX_MSGS = 20;
  localparam int MEAN_MAX = 843314857;  // pi in Q3.28

  // one request: mean anomaly (Q3.28) and eccentricity (Q0.32)
  typedef struct {
    logic signed [MeanW-1:0] mean;
    logic [EccW-1:0]         ecc;
  } kepler_req_t;

  // one solution as the core should report it
  typedef struct {
    logic [EaW-1:0]   ea;
    logic [StepW-1:0] steps;
    logic             conv;
  } kepler_sol_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [MeanW-1:0]  mean_anomaly_i = '0;
  logic [EccW-1:0]          eccentricity_i = '0;
  logic                     done_o;
  logic signed [EaW-1:0]    eccentric_anomaly_o;
  logic [StepW-1:0]         iterations_used_o;
  logic                     converged_o;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i = '0;
  logic [CfgDataW-1:0]      cfg_data_i = '0;

  kepler_eccentric_anomaly_solver_core #(
    .ANGLE_WIDTH  (ANGLE_W),
    .CORDIC_STAGES(STAGES)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .mean_anomaly_i     (mean_anomaly_i),
    .eccentricity_i     (eccentricity_i),
    .done_o             (done_o),
    .eccentric_anomaly_o(eccentric_anomaly_o),
    .iterations_used_o  (iterations_used_o),
    .converged_o        (converged_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: shadow registers and the arctangent table
  // --------------------------------------------------------------------------
  logic [ThrW-1:0]  thr_cfg = ThrReset;
  logic [StepW-1:0] lim_cfg = LimitReset;
  longint           atan_tbl [STAGES];

  kepler_req_t request_q [$];   // requests not yet presented
  kepler_sol_t solution_q [$];  // solutions owed by the core, oldest first

  int  n_req, n_res, n_conv, n_limit, n_cfg, err_cnt;

  // Change of fraction bits; narrowing rounds half up, shifts are arithmetic.
  function automatic longint frac_shift(longint v, int from, int to);
    if (to >= from) return v <<< (to - from);
    return (v + (longint'(1) <<< (from - to - 1))) >>> (from - to);
  endfunction

  // atan(2^-i) from the truncated odd-power series, 60 fraction bits
  function automatic void build_atan_tbl();
    longint acc, term;
    int     i, n;
    bit     neg;
    for (i = 0; i < STAGES; i++) begin
      acc = 0;
      neg = 1'b0;
      if (i == 0) begin
        acc = longint'(PiQ60 >> 2);
      end else begin
        for (n = 1; i * n < 60; n += 2) begin
          term = longint'((64'd1 << (60 - i * n)) / 64'(n));
          acc  = neg ? acc - term : acc + term;
          neg  = ~neg;
        end
      end
      atan_tbl[i] = frac_shift(acc, 60, FRAC);
    end
  endfunction

  // sin of a Q3.28 angle in Q1.28: fold into -pi/2..pi/2, then rotate
  function automatic longint cordic_sine(longint ang);
    longint pi_f, half_f, z, x, y, dx, dy;
    int     i;
    pi_f   = frac_shift(longint'(PiQ60), 60, FRAC);
    half_f = pi_f >>> 1;
    z      = frac_shift(ang, 28, FRAC);
    x      = frac_shift(longint'(GainQ60), 60, FRAC);
    y      = 0;
    if (z > pi_f) z -= 2 * pi_f;
    if (z < -pi_f) z += 2 * pi_f;
    if (z > half_f) z = pi_f - z;
    else if (z < -half_f) z = -pi_f - z;
    for (i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_tbl[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_tbl[i];
      end
    end
    return frac_shift(y, FRAC, 28);
  endfunction

  // E <- M + round(e * sin(E)) until the change drops below the threshold
  // or the step limit is reached (a limit of zero means one step).
  function automatic kepler_sol_t solve_kepler(kepler_req_t rq);
    kepler_sol_t r;
    longint      m, e, cur, nxt, dlt, prod;
    int          lim, steps;
    bit          fin;
    m     = longint'(rq.mean);
    e     = longint'({32'd0, rq.ecc});
    lim   = (lim_cfg == 0) ? 1 : int'(lim_cfg);
    cur   = m;
    steps = 0;
    fin   = 1'b0;
    r.conv = 1'b0;
    while (!fin) begin
      prod = (e * cordic_sine(cur) + (longint'(1) <<< 31)) >>> 32;
      nxt  = m + prod;
      dlt  = nxt - cur;
      if (dlt < 0) dlt = -dlt;
      cur = nxt;
      steps++;
      if (dlt < longint'({43'd0, thr_cfg})) begin
        r.conv = 1'b1;
        fin    = 1'b1;
      end else if (steps >= lim) begin
        fin = 1'b1;
      end
    end
    r.ea    = cur[EaW-1:0];
    r.steps = steps[StepW-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. Gaps: mostly none or short, a few long. Now and then it
  // holds off until every outstanding solution has come back.
  // --------------------------------------------------------------------------
  bit          gaps_on = 1'b1;
  int          gap_left = 0;
  bit          drain_hold = 1'b0;
  kepler_req_t next_rq;

  function automatic int draw_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 300);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        // request taken at this edge: predict with the current settings
        solution_q.push_back(solve_kepler('{mean: mean_anomaly_i, ecc: eccentricity_i}));
        n_req++;
      end
      // only choose the next value of start when not still waiting on busy
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (drain_hold && solution_q.size() != 0) begin
          start <= 1'b0;
        end else if (request_q.size() != 0) begin
          next_rq        = request_q.pop_front();
          mean_anomaly_i <= next_rq.mean;
          eccentricity_i <= next_rq.ecc;
          start          <= 1'b1;
          gap_left       = draw_gap();
          drain_hold     = ($urandom_range(0, 39) == 0);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: done_o is a one-cycle strobe, compared field by field
  // --------------------------------------------------------------------------
  kepler_sol_t want;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_res++;
      if (solution_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_MSGS)
          $display("%0t: result with no request outstanding: E=%0d steps=%0d conv=%0b",
                   $time, eccentric_anomaly_o, iterations_used_o, converged_o);
      end else begin
        want = solution_q.pop_front();
        if (converged_o) n_conv++;
        else n_limit++;
        if (eccentric_anomaly_o !== want.ea || iterations_used_o !== want.steps ||
            converged_o !== want.conv) begin
          err_cnt++;
          if (err_cnt <= MAX_MSGS)
            $display("%0t: mismatch E exp %0d got %0d, steps exp %0d got %0d, conv exp %0b got %0b",
                     $time, $signed(want.ea), eccentric_anomaly_o, want.steps,
                     iterations_used_o, want.conv, converged_o);
        end
      end
    end
  end

  // Watchdog: cycles with neither a request nor a result taken.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("%0t: no progress for %0d cycles, %0d solutions outstanding",
               $time, WDOG_MAX, solution_q.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence helpers
  // --------------------------------------------------------------------------
  task automatic add_request(int mean, logic [EccW-1:0] ecc);
    kepler_req_t rq;
    rq.mean = mean[MeanW-1:0];
    rq.ecc  = ecc;
    request_q.push_back(rq);
  endtask

  // register writes only while the core is idle
  task automatic write_reg(kea_reg_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == REG_THRESHOLD) thr_cfg = val[ThrW-1:0];
    else lim_cfg = val[StepW-1:0];
    n_cfg++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [ThrW-1:0] thr, logic [StepW-1:0] lim);
    write_reg(REG_THRESHOLD, CfgDataW'(thr));
    write_reg(REG_ITER_LIMIT, CfgDataW'(lim));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (request_q.size() != 0 || start || solution_q.size() != 0)
      @(negedge clk_i);
  endtask

  // mostly inside +-pi; some raw 31-bit values reach past pi
  function automatic int rand_mean();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return int'($urandom_range(2 * MEAN_MAX)) - MEAN_MAX;
    if (r < 9) return int'({{1{1'b0}}, $urandom()} << 1) >>> 1;
    return ($urandom_range(0, 1) != 0) ? MEAN_MAX : -MEAN_MAX;
  endfunction

  // full-range, near one, small, and below-one-half eccentricities
  function automatic logic [EccW-1:0] rand_ecc();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom();
    if (r < 6) return 32'hFFFF_FFFF - $urandom_range(0, 32'h00FF_FFFF);
    if (r < 8) return $urandom_range(0, 32'h1000_0000);
    return $urandom_range(0, 32'h7FFF_FFFF);
  endfunction

  task automatic add_random(int count);
    repeat (count) add_request(rand_mean(), rand_ecc());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  int              ph, bits;
  logic [ThrW-1:0]  r_thr;
  logic [StepW-1:0] r_lim;

  initial begin
    build_atan_tbl();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings (threshold 1, limit 30): angle and eccentricity corners.
    add_request(0, 32'h0000_0000);
    add_request(0, 32'hFFFF_FFFF);            // e near one
    add_request(MEAN_MAX, 32'h0000_0000);
    add_request(-MEAN_MAX, 32'h0000_0000);
    add_request(MEAN_MAX, 32'h8000_0000);
    add_request(-MEAN_MAX, 32'hFFFF_FFFF);
    add_request(32'h3FFF_FFFF, 32'h5555_5555); // largest M, beyond pi
    add_request(-32'h4000_0000, 32'hAAAA_AAAA); // most negative M
    add_request(MEAN_MAX / 2, 32'h1999_999A);  // around pi/2
    add_request(-MEAN_MAX / 2, 32'hCCCC_CCCC);
    add_request(1, 32'h0000_0001);
    add_request(-1, 32'hFFFF_FFFF);
    wait_drained();

    // Threshold zero never converges; limit zero acts as one step.
    set_config('0, '0);
    add_request(0, 32'h0000_0000);
    add_request(268435456, 32'h4000_0000);
    add_request(-1, 32'h0000_0001);
    wait_drained();

    // Limit of one: e = 0 converges on the single allowed step.
    set_config(21'd1, 6'd1);
    add_request(0, 32'h0000_0000);
    add_request(MEAN_MAX, 32'h0000_0000);
    add_request(MEAN_MAX, 32'h8000_0000);
    wait_drained();

    // Largest threshold and limit.
    set_config({ThrW{1'b1}}, {StepW{1'b1}});
    add_request(0, 32'hFFFF_FFFF);
    add_request(-MEAN_MAX, 32'h7FFF_FFFF);
    add_random(150);
    wait_drained();

    // Slowest setting: every solve runs all 63 steps.
    set_config('0, {StepW{1'b1}});
    add_random(10);
    wait_drained();

    // Random settings; one phase without sender gaps.
    for (ph = 0; ph < 8; ph++) begin
      bits  = $urandom_range(0, ThrW);
      r_thr = (bits == 0) ? '0 : ThrW'($urandom_range(0, (1 << bits) - 1));
      r_lim = (bits < 2) ? StepW'($urandom_range(0, 16)) : StepW'($urandom_range(0, 63));
      gaps_on = (ph != 3);
      set_config(r_thr, r_lim);
      add_random(160);
      wait_drained();
    end

    repeat (50) @(posedge clk_i);
    if (solution_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d solutions never returned", $time, solution_q.size());
    end
    $display("Run covered %0d requests and %0d results: %0d converged, %0d hit the limit.",
             n_req, n_res, n_conv, n_limit);
    $display("Settings spanned %0d register writes, thresholds 0..2^21-1, limits 0..63.",
             n_cfg);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors", err_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/kea_pkg.sv
rtl/kea_ctrl.sv
rtl/kea_datapath.sv
rtl/kepler_eccentric_anomaly_solver_core.sv
tb/tb.sv
